// ===== rtl/dmacf_pkg.sv =====
package dmacf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 28;
    localparam int unsigned LEN_W  = 24;
    localparam int unsigned IDX_W  = 3;

    localparam logic [IDX_W-1:0] IDX_SRC  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_DST  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_FILL = 3'd2;
    localparam logic [IDX_W-1:0] IDX_CMD  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_CTL  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_STS  = 3'd5;
    localparam logic [IDX_W-1:0] IDX_SP0  = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SP1  = 3'd7;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] TYPE_COPY = 2'd0;
    localparam logic [1:0] TYPE_FILL = 2'd2;

    localparam logic KIND_COPY = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    localparam logic [DATA_W-1:0] DONE_MASK = 32'h00FF_0000;
    localparam logic [DATA_W-1:0] IDLE_BIT  = 32'h0000_0008;
    localparam logic [DATA_W-1:0] OVF_BIT   = 32'h0000_0002;
    localparam logic [DATA_W-1:0] W1C_MASK  = DONE_MASK | IDLE_BIT | OVF_BIT;
    localparam logic [DATA_W-1:0] STS_RESET = 32'h0000_0100;

    localparam int unsigned UPDATE_POS = 31;
    localparam int unsigned DONE_POS   = 16;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    typedef struct packed {
        logic capture;
    } dp_cmd_t;

endpackage

// ===== rtl/dmacf_ctrl.sv =====
module dmacf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output dmacf_pkg::dp_cmd_t cmd
);

    dmacf_pkg::state_t state_reg;
    dmacf_pkg::state_t state_next;
    logic              accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmacf_pkg::ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dmacf_pkg::ST_EMPTY: begin
                if (accept) begin
                    state_next = dmacf_pkg::ST_FULL;
                end
            end
            dmacf_pkg::ST_FULL: begin
                if (m_ready && !accept) begin
                    state_next = dmacf_pkg::ST_EMPTY;
                end
            end
            default: state_next = dmacf_pkg::ST_EMPTY;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            dmacf_pkg::ST_EMPTY: begin
                s_ready = 1'b1;
            end
            dmacf_pkg::ST_FULL: begin
                s_ready = m_ready;
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
        cmd.capture = s_valid && s_ready;
    end

endmodule

// ===== rtl/dmacf_dp.sv =====
module dmacf_dp #(
    parameter int unsigned NUM_REGS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dmacf_pkg::dp_cmd_t                  cmd,
    input  logic                                s_op,
    input  logic [dmacf_pkg::IDX_W-1:0]         s_reg_index,
    input  logic [dmacf_pkg::DATA_W-1:0]        s_write_data,
    output logic [dmacf_pkg::DATA_W-1:0]        m_read_data,
    output logic                                m_irq_level,
    output logic                                m_start_valid,
    output logic                                m_xfer_kind,
    output logic [dmacf_pkg::ADDR_W-1:0]        m_xfer_source,
    output logic [dmacf_pkg::ADDR_W-1:0]        m_xfer_dest,
    output logic [dmacf_pkg::LEN_W-1:0]         m_xfer_length,
    output logic [dmacf_pkg::DATA_W-1:0]        m_fill_word
);

    logic [dmacf_pkg::ADDR_W-1:0] src_reg, src_next;
    logic [dmacf_pkg::ADDR_W-1:0] dst_reg, dst_next;
    logic [dmacf_pkg::DATA_W-1:0] fill_reg, fill_next;
    logic [dmacf_pkg::DATA_W-1:0] cmd_reg, cmd_next;
    logic [dmacf_pkg::DATA_W-1:0] ctl_reg, ctl_next;
    logic [dmacf_pkg::DATA_W-1:0] sts_reg, sts_next;
    logic                         irq_reg, irq_next;
    logic [1:0][dmacf_pkg::DATA_W-1:0] spare_q;

    logic                         wr;
    logic [1:0]                   cmd_type;
    logic [2:0]                   cmd_id;
    logic [dmacf_pkg::LEN_W-1:0]  cmd_len;
    logic                         launch;
    logic                         irq_upd;
    logic [dmacf_pkg::DATA_W-1:0] rd_mux;

    logic [dmacf_pkg::DATA_W-1:0] rd_data_next;
    logic                         sv_next;
    logic                         kind_next;
    logic [dmacf_pkg::ADDR_W-1:0] xsrc_next;
    logic [dmacf_pkg::ADDR_W-1:0] xdst_next;
    logic [dmacf_pkg::LEN_W-1:0]  xlen_next;
    logic [dmacf_pkg::DATA_W-1:0] fw_next;

    for (genvar k = 0; k < 2; k++) begin : g_spare
        if (6 + k < NUM_REGS) begin : g_on
            logic [dmacf_pkg::DATA_W-1:0] spare_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    spare_reg <= '0;
                end else if (cmd.capture && s_op == dmacf_pkg::OP_WRITE
                             && s_reg_index == 3'(6 + k)) begin
                    spare_reg <= s_write_data;
                end
            end
            assign spare_q[k] = spare_reg;
        end else begin : g_off
            assign spare_q[k] = '0;
        end
    end

    assign wr       = (s_op == dmacf_pkg::OP_WRITE);
    assign cmd_type = s_write_data[25:24];
    assign cmd_id   = s_write_data[30:28];
    assign cmd_len  = s_write_data[dmacf_pkg::LEN_W-1:0];
    assign launch   = wr && (s_reg_index == dmacf_pkg::IDX_CMD) && (cmd_len != '0)
                      && (cmd_type == dmacf_pkg::TYPE_COPY
                          || cmd_type == dmacf_pkg::TYPE_FILL);

    always_comb begin
        unique case (s_reg_index)
            dmacf_pkg::IDX_SRC:  rd_mux = {4'b0, src_reg};
            dmacf_pkg::IDX_DST:  rd_mux = {4'b0, dst_reg};
            dmacf_pkg::IDX_FILL: rd_mux = fill_reg;
            dmacf_pkg::IDX_CMD:  rd_mux = cmd_reg;
            dmacf_pkg::IDX_CTL:  rd_mux = ctl_reg;
            dmacf_pkg::IDX_STS:  rd_mux = sts_reg;
            dmacf_pkg::IDX_SP0:  rd_mux = spare_q[0];
            dmacf_pkg::IDX_SP1:  rd_mux = spare_q[1];
            default:             rd_mux = '0;
        endcase
    end

    always_comb begin
        src_next  = src_reg;
        dst_next  = dst_reg;
        fill_next = fill_reg;
        cmd_next  = cmd_reg;
        ctl_next  = ctl_reg;
        sts_next  = sts_reg;
        irq_upd   = 1'b0;
        if (wr) begin
            unique case (s_reg_index)
                dmacf_pkg::IDX_SRC:  src_next  = s_write_data[dmacf_pkg::ADDR_W-1:0];
                dmacf_pkg::IDX_DST:  dst_next  = s_write_data[dmacf_pkg::ADDR_W-1:0];
                dmacf_pkg::IDX_FILL: fill_next = s_write_data;
                dmacf_pkg::IDX_CMD: begin
                    cmd_next = s_write_data;
                    if (launch) begin
                        irq_upd = 1'b1;
                        if (s_write_data[dmacf_pkg::UPDATE_POS]) begin
                            sts_next = sts_reg
                                | (dmacf_pkg::DATA_W'(1) << (dmacf_pkg::DONE_POS + cmd_id));
                        end
                    end
                end
                dmacf_pkg::IDX_CTL: begin
                    ctl_next = s_write_data;
                    irq_upd  = 1'b1;
                end
                dmacf_pkg::IDX_STS: begin
                    sts_next = sts_reg & ~(s_write_data & dmacf_pkg::W1C_MASK);
                    irq_upd  = 1'b1;
                end
                default: ;
            endcase
        end
        irq_next = irq_upd ? (|(sts_next & ctl_next & dmacf_pkg::W1C_MASK)) : irq_reg;
    end

    always_comb begin
        rd_data_next = wr ? '0 : rd_mux;
        sv_next      = launch;
        kind_next    = dmacf_pkg::KIND_COPY;
        xsrc_next    = '0;
        xdst_next    = '0;
        xlen_next    = '0;
        fw_next      = '0;
        if (launch) begin
            xdst_next = dst_reg;
            if (cmd_type == dmacf_pkg::TYPE_FILL) begin
                kind_next = dmacf_pkg::KIND_FILL;
                xlen_next = {cmd_len[dmacf_pkg::LEN_W-1:2], 2'b00};
                fw_next   = fill_reg;
            end else begin
                xsrc_next = src_reg;
                xlen_next = cmd_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg  <= '0;
            dst_reg  <= '0;
            fill_reg <= '0;
            cmd_reg  <= '0;
            ctl_reg  <= '0;
            sts_reg  <= dmacf_pkg::STS_RESET;
            irq_reg  <= 1'b0;
        end else if (cmd.capture) begin
            src_reg  <= src_next;
            dst_reg  <= dst_next;
            fill_reg <= fill_next;
            cmd_reg  <= cmd_next;
            ctl_reg  <= ctl_next;
            sts_reg  <= sts_next;
            irq_reg  <= irq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            m_read_data   <= rd_data_next;
            m_irq_level   <= irq_next;
            m_start_valid <= sv_next;
            m_xfer_kind   <= kind_next;
            m_xfer_source <= xsrc_next;
            m_xfer_dest   <= xdst_next;
            m_xfer_length <= xlen_next;
            m_fill_word   <= fw_next;
        end
    end

endmodule

// ===== rtl/dma_copy_fill_register_block.sv =====
// A result is on the m_ side in the cycle after its transfer is accepted.
// Throughput: one access per cycle while m_ready is high; the single output
// register holds the input side while its result is not taken.
// Reset (aresetn, synchronous, active low): registers clear to zero, status
// to 0x100, internal interrupt flag low, output register empty.
module dma_copy_fill_register_block #(
    parameter int unsigned NUM_REGS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [dmacf_pkg::IDX_W-1:0]         s_reg_index,
    input  logic [dmacf_pkg::DATA_W-1:0]        s_write_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dmacf_pkg::DATA_W-1:0]        m_read_data,
    output logic                                m_irq_level,
    output logic                                m_start_valid,
    output logic                                m_xfer_kind,
    output logic [dmacf_pkg::ADDR_W-1:0]        m_xfer_source,
    output logic [dmacf_pkg::ADDR_W-1:0]        m_xfer_dest,
    output logic [dmacf_pkg::LEN_W-1:0]         m_xfer_length,
    output logic [dmacf_pkg::DATA_W-1:0]        m_fill_word
);

    dmacf_pkg::dp_cmd_t cmd;

    dmacf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dmacf_dp #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_op          (s_op),
        .s_reg_index   (s_reg_index),
        .s_write_data  (s_write_data),
        .m_read_data   (m_read_data),
        .m_irq_level   (m_irq_level),
        .m_start_valid (m_start_valid),
        .m_xfer_kind   (m_xfer_kind),
        .m_xfer_source (m_xfer_source),
        .m_xfer_dest   (m_xfer_dest),
        .m_xfer_length (m_xfer_length),
        .m_fill_word   (m_fill_word)
    );

    a_accept_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted access produced no result");

    a_no_xfer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_start_valid |-> m_xfer_length == '0 && m_xfer_dest == '0
            && m_xfer_source == '0 && m_fill_word == '0)
        else $error("descriptor fields set without a launch");

    a_fill_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_xfer_kind |-> m_start_valid && m_xfer_length[1:0] == 2'b00
            && m_xfer_source == '0)
        else $error("malformed fill descriptor");

    a_copy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_valid && !m_xfer_kind |-> m_xfer_length != '0
            && m_fill_word == '0)
        else $error("malformed copy descriptor");

    a_write_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_valid |-> m_read_data == '0)
        else $error("launching write returned read data");

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dmacf_pkg::*;

    localparam int unsigned NUM_REGS     = 8;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam logic [1:0] TYPE_RSV1 = 2'd1;
    localparam logic [1:0] TYPE_RSV3 = 2'd3;

    localparam logic [DATA_W-1:0] ADDR_MASK = {{(DATA_W-ADDR_W){1'b0}}, {ADDR_W{1'b1}}};

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              start_valid;
        logic              xfer_kind;
        logic [ADDR_W-1:0] xfer_source;
        logic [ADDR_W-1:0] xfer_dest;
        logic [LEN_W-1:0]  xfer_length;
        logic [DATA_W-1:0] fill_word;
    } access_result_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_op;
    logic [IDX_W-1:0]  s_reg_index;
    logic [DATA_W-1:0] s_write_data;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_read_data;
    logic              m_irq_level;
    logic              m_start_valid;
    logic              m_xfer_kind;
    logic [ADDR_W-1:0] m_xfer_source;
    logic [ADDR_W-1:0] m_xfer_dest;
    logic [LEN_W-1:0]  m_xfer_length;
    logic [DATA_W-1:0] m_fill_word;

    logic [DATA_W-1:0] shadow_regs [NUM_REGS];
    logic              shadow_irq;
    access_result_t    expected_results [$];

    int  mismatch_count = 0;
    int  accesses_sent  = 0;
    int  stall_cycles   = 0;
    bit  gaps_on        = 1'b1;
    bit  quiet          = 1'b0;
    bit  hold_request   = 1'b0;

    dma_copy_fill_register_block #(
        .NUM_REGS(NUM_REGS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_reg_index  (s_reg_index),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_level  (m_irq_level),
        .m_start_valid(m_start_valid),
        .m_xfer_kind  (m_xfer_kind),
        .m_xfer_source(m_xfer_source),
        .m_xfer_dest  (m_xfer_dest),
        .m_xfer_length(m_xfer_length),
        .m_fill_word  (m_fill_word)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void update_irq_line();
        logic [DATA_W-1:0] sts;
        logic [DATA_W-1:0] ctl;
        sts = shadow_regs[IDX_STS];
        ctl = shadow_regs[IDX_CTL];
        shadow_irq = ((sts & ctl & DONE_MASK) != '0) || ((sts & ctl & IDLE_BIT) != '0) ||
                     ((sts & ctl & OVF_BIT) != '0);
    endfunction

    function automatic access_result_t predict_register_access(
        logic op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        access_result_t   r;
        logic [1:0]       code;
        logic [2:0]       id;
        logic [LEN_W-1:0] len;
        r    = '0;
        code = data[25:24];
        id   = data[30:28];
        len  = data[LEN_W-1:0];
        if (int'(idx) < NUM_REGS) begin
            if (op == OP_READ) begin
                r.read_data = shadow_regs[idx];
            end else begin
                case (idx)
                    IDX_SRC, IDX_DST: begin
                        shadow_regs[idx] = data & ADDR_MASK;
                    end
                    IDX_CMD: begin
                        shadow_regs[idx] = data;
                        if (len != '0 && (code == TYPE_COPY || code == TYPE_FILL)) begin
                            r.start_valid = 1'b1;
                            r.xfer_dest   = shadow_regs[IDX_DST][ADDR_W-1:0];
                            if (code == TYPE_FILL) begin
                                r.xfer_kind   = KIND_FILL;
                                r.xfer_length = {len[LEN_W-1:2], 2'b00};
                                r.fill_word   = shadow_regs[IDX_FILL];
                            end else begin
                                r.xfer_kind   = KIND_COPY;
                                r.xfer_source = shadow_regs[IDX_SRC][ADDR_W-1:0];
                                r.xfer_length = len;
                            end
                            if (data[UPDATE_POS])
                                shadow_regs[IDX_STS][DONE_POS + id] = 1'b1;
                            update_irq_line();
                        end
                    end
                    IDX_CTL: begin
                        shadow_regs[idx] = data;
                        update_irq_line();
                    end
                    IDX_STS: begin
                        shadow_regs[idx] = shadow_regs[idx] & ~(data & W1C_MASK);
                        update_irq_line();
                    end
                    default: begin
                        shadow_regs[idx] = data;
                    end
                endcase
            end
        end
        r.irq_level = shadow_irq;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] command_word(
        logic update, logic [2:0] id, logic [1:0] code, logic [LEN_W-1:0] len);
        return {update, id, 2'b00, code, len};
    endfunction

    function automatic logic [DATA_W-1:0] random_command();
        logic [DATA_W-1:0] word;
        logic [1:0]        code;
        logic [LEN_W-1:0]  len;
        int                pick;
        word = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            code = TYPE_COPY;
        else if (pick < 8)
            code = TYPE_FILL;
        else if (pick == 8)
            code = TYPE_RSV1;
        else
            code = TYPE_RSV3;
        case ($urandom_range(0, 7))
            0:       len = '0;
            1:       len = LEN_W'($urandom_range(1, 3));
            2:       len = {LEN_W{1'b1}};
            3, 4:    len = LEN_W'($urandom_range(1, 64));
            default: len = LEN_W'($urandom);
        endcase
        word[25:24]      = code;
        word[LEN_W-1:0]  = len;
        return word;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatch_count++;
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // one access: optional random gap, then hold valid until the transfer
    task automatic send_access(logic op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        int gap;
        if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_reg_index  <= idx;
        s_write_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_register_access(op, idx, data));
        accesses_sent++;
    endtask

    task automatic release_bus();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 9) < 7) send_access(OP_WRITE, IDX_SRC, $urandom);
            if ($urandom_range(0, 9) < 7) send_access(OP_WRITE, IDX_DST, $urandom);
            if ($urandom_range(0, 9) < 7) send_access(OP_WRITE, IDX_FILL, $urandom);
            send_access(OP_WRITE, IDX_CMD, random_command());
            if ($urandom_range(0, 9) < 4) send_access(OP_READ, IDX_STS, $urandom);
        end else if (pick < 62) begin
            if ($urandom_range(0, 1) == 0)
                send_access(OP_WRITE, IDX_CTL, $urandom & DONE_MASK);
            else
                send_access(OP_WRITE, IDX_CTL, $urandom);
        end else if (pick < 74) begin
            send_access(OP_WRITE, IDX_STS, $urandom);
        end else if (pick < 90) begin
            send_access(OP_READ, IDX_W'($urandom_range(0, 7)), $urandom);
        end else begin
            send_access(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 7)), $urandom);
        end
    endtask

    task automatic test_reset_state();
        send_access(OP_READ, IDX_STS, '0);
        send_access(OP_READ, IDX_SRC, '1);
    endtask

    task automatic test_address_masking();
        send_access(OP_WRITE, IDX_SRC, '1);
        send_access(OP_WRITE, IDX_DST, '1);
        send_access(OP_WRITE, IDX_FILL, 32'hDEAD_BEEF);
        send_access(OP_READ, IDX_SRC, '0);
        send_access(OP_READ, IDX_DST, '0);
    endtask

    task automatic test_command_launch();
        send_access(OP_WRITE, IDX_CTL, DONE_MASK | IDLE_BIT | OVF_BIT);
        send_access(OP_WRITE, IDX_CMD, command_word(1'b1, 3'd7, TYPE_COPY, '1));
        // fill shorter than a dword still launches, with zero length
        send_access(OP_WRITE, IDX_CMD, command_word(1'b1, 3'd0, TYPE_FILL, 24'd3));
        send_access(OP_WRITE, IDX_CMD, command_word(1'b0, 3'd5, TYPE_FILL, '1));
        send_access(OP_WRITE, IDX_CMD, command_word(1'b1, 3'd1, TYPE_COPY, '0));
        send_access(OP_WRITE, IDX_CMD, command_word(1'b1, 3'd2, TYPE_RSV1, 24'h10));
        send_access(OP_WRITE, IDX_CMD, command_word(1'b1, 3'd3, TYPE_RSV3, 24'h10));
        send_access(OP_READ, IDX_CMD, '0);
        send_access(OP_READ, IDX_STS, '0);
    endtask

    task automatic test_status_clear_and_irq();
        send_access(OP_WRITE, IDX_STS, '1);
        send_access(OP_READ, IDX_STS, '0);
        send_access(OP_WRITE, IDX_CTL, '0);
        send_access(OP_WRITE, IDX_CMD, command_word(1'b1, 3'd2, TYPE_COPY, 24'd1));
        send_access(OP_WRITE, IDX_CTL, 32'h0004_0000);
        send_access(OP_WRITE, IDX_STS, '0);
    endtask

    task automatic test_spare_storage();
        send_access(OP_WRITE, IDX_SP0, '1);
        send_access(OP_WRITE, IDX_SP1, '0);
        send_access(OP_READ, IDX_SP0, '0);
        send_access(OP_READ, IDX_SP1, '1);
    endtask

    task automatic test_random_traffic(int target);
        while (accesses_sent < target) send_random_item();
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        int stop_at;
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        stop_at      = accesses_sent + 40;
        while (accesses_sent < stop_at) send_random_item();
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        int stop_at;
        stop_at = accesses_sent + 20;
        while (accesses_sent < stop_at) send_random_item();
        release_bus();
        wait_results_drained();
        stop_at = accesses_sent + 20;
        while (accesses_sent < stop_at) send_random_item();
    endtask

    task automatic test_full_rate();
        int stop_at;
        quiet   = 1'b1;
        stop_at = accesses_sent + 250;
        while (accesses_sent < stop_at) send_random_item();
    endtask

    initial begin : receiver
        int burst;
        burst   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (burst > 0) begin
                m_ready <= 1'b0;
                burst--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 14) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        access_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result read_data", m_read_data, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_read_data !== want.read_data)
                    report_mismatch("read_data", m_read_data, want.read_data);
                if (m_irq_level !== want.irq_level)
                    report_mismatch("irq_level", DATA_W'(m_irq_level),
                                    DATA_W'(want.irq_level));
                if (m_start_valid !== want.start_valid)
                    report_mismatch("start_valid", DATA_W'(m_start_valid),
                                    DATA_W'(want.start_valid));
                if (m_xfer_kind !== want.xfer_kind)
                    report_mismatch("xfer_kind", DATA_W'(m_xfer_kind),
                                    DATA_W'(want.xfer_kind));
                if (m_xfer_source !== want.xfer_source)
                    report_mismatch("xfer_source", DATA_W'(m_xfer_source),
                                    DATA_W'(want.xfer_source));
                if (m_xfer_dest !== want.xfer_dest)
                    report_mismatch("xfer_dest", DATA_W'(m_xfer_dest),
                                    DATA_W'(want.xfer_dest));
                if (m_xfer_length !== want.xfer_length)
                    report_mismatch("xfer_length", DATA_W'(m_xfer_length),
                                    DATA_W'(want.xfer_length));
                if (m_fill_word !== want.fill_word)
                    report_mismatch("fill_word", m_fill_word, want.fill_word);
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_READ;
        s_reg_index  = IDX_SRC;
        s_write_data = '0;
        for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
        shadow_regs[IDX_STS] = STS_RESET;
        shadow_irq = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_address_masking();
        test_command_launch();
        test_status_clear_and_irq();
        test_spare_storage();
        test_random_traffic(1400);
        test_output_backpressure();
        test_drain_pause();
        test_full_rate();

        release_bus();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
